/* rtl/core/sap_pkg.sv */
// shared types and constants of the stereo allpass phaser
package sap_pkg;

	// register indexes
	localparam logic [2:0] REG_LFO_STEP      = 3'd0;
	localparam logic [2:0] REG_SWEEP_DEPTH   = 3'd1;
	localparam logic [2:0] REG_STAGE_SELECT  = 3'd2;
	localparam logic [2:0] REG_FEEDBACK_GAIN = 3'd3;
	localparam logic [2:0] REG_WET_MIX       = 3'd4;
	localparam logic [2:0] REG_SWEEP_LOW     = 3'd5;
	localparam logic [2:0] REG_SWEEP_HIGH    = 3'd6;

	// register reset values
	localparam logic [23:0] RST_LFO_STEP      = 24'd237;
	localparam logic [15:0] RST_SWEEP_DEPTH   = 16'd51400;
	localparam logic [7:0]  RST_STAGE_SELECT  = 8'd64;
	localparam logic [15:0] RST_FEEDBACK_GAIN = 16'd13880;
	localparam logic [16:0] RST_WET_MIX       = 17'd38550;
	localparam logic [14:0] RST_SWEEP_LOW     = 15'd137;
	localparam logic [14:0] RST_SWEEP_HIGH    = 15'd5461;

	// item modes
	localparam logic MODE_PROCESS = 1'b0;
	localparam logic MODE_CLEAR   = 1'b1;

	// sine polynomial coefficients, q1.30, then unity in q23 and q16
	localparam logic signed [32:0] POLY_C1 = 33'sd1686629705;
	localparam logic signed [32:0] POLY_C3 = 33'sd688904862;
	localparam logic signed [32:0] POLY_C5 = 33'sd76016981;
	localparam logic signed [25:0] ONE_Q23 = 26'sd8388608;
	localparam logic [16:0]        UNITY_Q16 = 17'd65536;

	// lane control group
	typedef struct packed {
		logic start;
		logic clear;
	} lane_ctrl_t;

	typedef logic signed [24:0] coef_t;

endpackage

/* rtl/core/sap_in_if.sv */
// input channel interface: mode and sample pair
interface sap_in_if #(parameter int W = 24);
	logic         valid;
	logic         ready;
	logic         mode;
	logic [W-1:0] left_in;
	logic [W-1:0] right_in;
	modport source (output valid, mode, left_in, right_in, input ready);
	modport sink (input valid, mode, left_in, right_in, output ready);
endinterface

/* rtl/core/sap_out_if.sv */
// output channel interface: mixed sample pair
interface sap_out_if #(parameter int W = 24);
	logic         valid;
	logic         ready;
	logic [W-1:0] left_out;
	logic [W-1:0] right_out;
	modport source (output valid, left_out, right_out, input ready);
	modport sink (input valid, left_out, right_out, output ready);
endinterface

/* rtl/core/sap_cfg_if.sv */
// configuration write channel interface
interface sap_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  addr;
	logic [23:0] data;
	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

/* rtl/core/sap_coef.sv */
// allpass coefficient unit: lfo sine, cutoff, sine/cosine and serial divide
module sap_coef import sap_pkg::*; #(
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [23:0] phase,
	input  logic [15:0] depth,
	input  logic [14:0] sweep_low,
	input  logic [14:0] sweep_high,
	output logic        done,
	output coef_t       coef
);
	localparam int TB = SINE_TABLE_BITS;

	localparam logic [3:0] C_IDLE = 4'd0;
	localparam logic [3:0] C_SIN0 = 4'd1;
	localparam logic [3:0] C_SIN1 = 4'd2;
	localparam logic [3:0] C_SIN2 = 4'd3;
	localparam logic [3:0] C_SIN3 = 4'd4;
	localparam logic [3:0] C_SIN4 = 4'd5;
	localparam logic [3:0] C_SIN5 = 4'd6;
	localparam logic [3:0] C_LV   = 4'd7;
	localparam logic [3:0] C_FC   = 4'd8;
	localparam logic [3:0] C_FCD  = 4'd9;
	localparam logic [3:0] C_DIV0 = 4'd10;
	localparam logic [3:0] C_DIVI = 4'd11;
	localparam logic [3:0] C_DONE = 4'd12;

	localparam logic [1:0] SEL_LFO = 2'd0;
	localparam logic [1:0] SEL_SIN = 2'd1;
	localparam logic [1:0] SEL_COS = 2'd2;

	logic [3:0]         state_q;
	logic [1:0]         sel_q;
	logic [23:0]        ph_q;
	logic [30:0]        u_q;
	logic [30:0]        u2_q;
	logic               quad_hi_q;
	logic signed [24:0] s_q, sv_q, cv_q;
	logic signed [65:0] prod_q;
	logic signed [32:0] mul_a, mul_b;
	logic [25:0]        rem_q;
	logic [24:0]        den_q;
	logic               bit0_q;
	logic [23:0]        quo_q;
	logic               neg_q;
	logic [4:0]         cnt_q;
	logic               done_q;
	coef_t              coef_q;

	// sine front end
	logic [TB-1:0]      idx;
	logic [29:0]        u_raw;
	logic [30:0]        u_val;
	logic signed [65:0] shr30;
	logic signed [32:0] y_neg;
	logic signed [32:0] y_pos;
	logic signed [24:0] sine_val;
	// cutoff and divide helpers
	logic signed [65:0] fc_val;
	logic signed [25:0] den;
	logic signed [25:0] mag;
	logic [25:0]        r2;
	logic               ge;

	always_comb begin
		idx   = ph_q[23 -: TB];
		u_raw = {idx[TB-3:0], {(32-TB){1'b0}}};
		if (idx[TB-2]) begin
			u_val = 31'h4000_0000 - {1'b0, u_raw};
		end else begin
			u_val = {1'b0, u_raw};
		end
		shr30    = prod_q >>> 30;
		y_pos    = shr30[32:0];
		y_neg    = -shr30[32:0];
		sine_val = quad_hi_q ? 25'(y_neg >>> 7) : 25'(y_pos >>> 7);
		fc_val   = 66'(signed'({1'b0, sweep_low})) + (prod_q >>> 23);
		den      = ONE_Q23 + 26'(sv_q);
		mag      = (cv_q < 0) ? -26'(cv_q) : 26'(cv_q);
		r2       = {rem_q[24:0], (cnt_q == 5'd23) ? bit0_q : 1'b0};
		ge       = r2 >= {1'b0, den_q};
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			C_SIN1: begin
				mul_a = 33'(signed'({1'b0, u_q}));
				mul_b = 33'(signed'({1'b0, u_q}));
			end
			C_SIN2: begin
				mul_a = 33'(signed'({1'b0, shr30[30:0]}));
				mul_b = POLY_C5;
			end
			C_SIN3: begin
				mul_a = 33'(signed'({1'b0, u2_q}));
				mul_b = POLY_C3 - shr30[32:0];
			end
			C_SIN4: begin
				mul_a = 33'(signed'({1'b0, u_q}));
				mul_b = POLY_C1 - shr30[32:0];
			end
			C_LV: begin
				mul_a = 33'((26'(s_q) + ONE_Q23) >>> 1);
				mul_b = 33'(signed'({1'b0, depth}));
			end
			C_FC: begin
				mul_a = 33'(prod_q >>> 16);
				mul_b = 33'(signed'({1'b0, sweep_high})) - 33'(signed'({1'b0, sweep_low}));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						ph_q    <= phase;
						sel_q   <= SEL_LFO;
						state_q <= C_SIN0;
					end
				end
				C_SIN0: begin
					u_q       <= u_val;
					quad_hi_q <= idx[TB-1];
					state_q   <= C_SIN1;
				end
				C_SIN1: state_q <= C_SIN2;
				C_SIN2: begin
					u2_q    <= shr30[30:0];
					state_q <= C_SIN3;
				end
				C_SIN3: state_q <= C_SIN4;
				C_SIN4: state_q <= C_SIN5;
				C_SIN5: begin
					unique case (sel_q)
						SEL_LFO: begin
							s_q     <= sine_val;
							state_q <= C_LV;
						end
						SEL_SIN: begin
							sv_q    <= sine_val;
							ph_q    <= ph_q + 24'h40_0000;
							sel_q   <= SEL_COS;
							state_q <= C_SIN0;
						end
						default: begin
							cv_q    <= sine_val;
							state_q <= C_DIV0;
						end
					endcase
				end
				C_LV: state_q <= C_FC;
				C_FC: state_q <= C_FCD;
				C_FCD: begin
					ph_q    <= {fc_val[15:0], 8'h00};
					sel_q   <= SEL_SIN;
					state_q <= C_SIN0;
				end
				C_DIV0: begin
					neg_q <= cv_q > 0;
					if (den <= 0) begin
						quo_q   <= '0;
						state_q <= C_DONE;
					end else if ({1'b0, mag} >= {den, 1'b0}) begin
						// quotient beyond one, clamp
						quo_q   <= 24'h80_0000;
						state_q <= C_DONE;
					end else begin
						rem_q   <= 26'(mag >>> 1);
						bit0_q  <= mag[0];
						den_q   <= den[24:0];
						quo_q   <= '0;
						cnt_q   <= 5'd23;
						state_q <= C_DIVI;
					end
				end
				C_DIVI: begin
					rem_q <= ge ? (r2 - {1'b0, den_q}) : r2;
					quo_q <= {quo_q[22:0], ge};
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						state_q <= C_DONE;
					end
				end
				C_DONE: begin
					if (quo_q > 24'h80_0000) begin
						coef_q <= neg_q ? -25'sd8388608 : 25'sd8388608;
					end else begin
						coef_q <= neg_q ? -signed'({1'b0, quo_q}) : signed'({1'b0, quo_q});
					end
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign coef = coef_q;

endmodule

/* rtl/core/sap_lane.sv */
// one channel lane: feedback, allpass cascade stepped by stage, dry/wet mix
module sap_lane import sap_pkg::*; #(
	parameter int MAX_STAGE_COUNT = 8,
	parameter int SAMPLE_BITS     = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lane_ctrl_t                    ctrl,
	input  coef_t                         coef,
	input  logic [15:0]                   gain,
	input  logic [16:0]                   wet,
	input  logic [$clog2(MAX_STAGE_COUNT+1)-1:0] stages,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          done,
	output logic signed [SAMPLE_BITS-1:0] result
);
	localparam int W  = SAMPLE_BITS;
	localparam int XW = W + 28;
	localparam int CW = $clog2(MAX_STAGE_COUNT + 1);
	localparam int IW = $clog2(MAX_STAGE_COUNT);
	localparam logic signed [XW-1:0] HI_X = XW'((64'sd1 <<< (W - 1)) - 64'sd1);
	localparam logic signed [XW-1:0] LO_X = -HI_X - XW'(1);

	localparam logic [2:0] L_IDLE = 3'd0;
	localparam logic [2:0] L_FB   = 3'd1;
	localparam logic [2:0] L_MUL  = 3'd2;
	localparam logic [2:0] L_ADD  = 3'd3;
	localparam logic [2:0] L_MIX  = 3'd4;
	localparam logic [2:0] L_FIN  = 3'd5;

	function automatic logic signed [W-1:0] sat(input logic signed [XW-1:0] v);
		if (v > HI_X) begin
			return HI_X[W-1:0];
		end else if (v < LO_X) begin
			return LO_X[W-1:0];
		end
		return v[W-1:0];
	endfunction

	logic [2:0]            state_q;
	logic [CW-1:0]         cnt_q;
	logic signed [W-1:0]   x1_q [MAX_STAGE_COUNT];
	logic signed [W-1:0]   y1_q [MAX_STAGE_COUNT];
	logic signed [W-1:0]   fb_q;
	logic signed [W-1:0]   x_q;
	logic signed [W-1:0]   out_q;
	logic signed [XW-1:0]  pa_q, pb_q;
	logic                  done_q;
	logic signed [W:0]     diff;
	logic signed [W-1:0]   y_new;
	logic signed [17:0]    dry_gain;

	always_comb begin
		diff     = (W + 1)'(x_q) - (W + 1)'(y1_q[cnt_q[IW-1:0]]);
		y_new    = sat((pa_q >>> 23) + XW'(x1_q[cnt_q[IW-1:0]]));
		dry_gain = signed'({1'b0, UNITY_Q16 - wet});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done_q  <= 1'b0;
			fb_q    <= '0;
			for (int i = 0; i < MAX_STAGE_COUNT; i++) begin
				x1_q[i] <= '0;
				y1_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				L_IDLE: begin
					if (ctrl.clear) begin
						fb_q <= '0;
						for (int i = 0; i < MAX_STAGE_COUNT; i++) begin
							x1_q[i] <= '0;
							y1_q[i] <= '0;
						end
					end else if (ctrl.start) begin
						pa_q    <= fb_q * signed'({1'b0, gain});
						state_q <= L_FB;
					end
				end
				L_FB: begin
					x_q     <= sat(XW'(sample) + (pa_q >>> 16));
					cnt_q   <= '0;
					state_q <= L_MUL;
				end
				L_MUL: begin
					pa_q    <= coef * diff;
					state_q <= L_ADD;
				end
				L_ADD: begin
					x1_q[cnt_q[IW-1:0]] <= x_q;
					y1_q[cnt_q[IW-1:0]] <= y_new;
					x_q <= y_new;
					if (cnt_q == stages - CW'(1)) begin
						state_q <= L_MIX;
					end else begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= L_MUL;
					end
				end
				L_MIX: begin
					pa_q    <= sample * dry_gain;
					pb_q    <= x_q * signed'({1'b0, wet});
					fb_q    <= x_q;
					state_q <= L_FIN;
				end
				L_FIN: begin
					out_q   <= sat((pa_q + pb_q) >>> 16);
					done_q  <= 1'b1;
					state_q <= L_IDLE;
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = out_q;

endmodule

/* rtl/core/stereo_allpass_phaser.sv */
// top level of the stereo allpass phaser
// Stereo phaser: each process item carries one left/right pair and yields one
// mixed pair; a clear item zeroes filter, lfo and feedback state and yields
// nothing. For a process item the coefficient unit runs three sine
// evaluations and the cutoff on one shared multiplier, then a 24-step
// restoring divide, and the two channel lanes then step their allpass stages
// in parallel, a multiply state and an add state per stage, before the mix.
// A new item is taken once the previous one has left the lanes; a finished
// pair waits in the output register meanwhile.
module stereo_allpass_phaser import sap_pkg::*; #(
	parameter int MAX_STAGE_COUNT = 8,
	parameter int SAMPLE_BITS     = 24,
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	sap_in_if.sink    in_ch,
	sap_out_if.source out_ch,
	sap_cfg_if.sink   cfg_ch
);
	localparam int W  = SAMPLE_BITS;
	localparam int CW = $clog2(MAX_STAGE_COUNT + 1);

	localparam logic [1:0] T_IDLE = 2'd0;
	localparam logic [1:0] T_COEF = 2'd1;
	localparam logic [1:0] T_LANE = 2'd2;
	localparam logic [1:0] T_OUT  = 2'd3;

	// configuration registers
	logic [23:0] lfo_step_q;
	logic [15:0] sweep_depth_q;
	logic [7:0]  stage_select_q;
	logic [15:0] feedback_gain_q;
	logic [16:0] wet_mix_q;
	logic [14:0] sweep_low_q;
	logic [14:0] sweep_high_q;

	logic [1:0]          state_q;
	logic [23:0]         lfo_phase_q;
	logic signed [W-1:0] smp_l_q, smp_r_q;
	logic                out_valid_q;
	logic signed [W-1:0] out_l_q, out_r_q;

	logic          accept;
	logic          load_out;
	logic          coef_start;
	logic          coef_done;
	coef_t         coef;
	lane_ctrl_t    lane_ctrl;
	logic          done_l, done_r;
	logic signed [W-1:0] res_l, res_r;
	logic [16:0]   wet_eff;
	logic [4:0]    stage_raw;
	logic [CW-1:0] stages;

	// config port never stalls
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfo_step_q      <= RST_LFO_STEP;
			sweep_depth_q   <= RST_SWEEP_DEPTH;
			stage_select_q  <= RST_STAGE_SELECT;
			feedback_gain_q <= RST_FEEDBACK_GAIN;
			wet_mix_q       <= RST_WET_MIX;
			sweep_low_q     <= RST_SWEEP_LOW;
			sweep_high_q    <= RST_SWEEP_HIGH;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.addr)
				REG_LFO_STEP:      lfo_step_q      <= cfg_ch.data;
				REG_SWEEP_DEPTH:   sweep_depth_q   <= cfg_ch.data[15:0];
				REG_STAGE_SELECT:  stage_select_q  <= cfg_ch.data[7:0];
				REG_FEEDBACK_GAIN: feedback_gain_q <= cfg_ch.data[15:0];
				REG_WET_MIX:       wet_mix_q       <= cfg_ch.data[16:0];
				REG_SWEEP_LOW:     sweep_low_q     <= cfg_ch.data[14:0];
				REG_SWEEP_HIGH:    sweep_high_q    <= cfg_ch.data[14:0];
				default: ; // unknown index, ignored
			endcase
		end
	end

	// stage count 2, 4, 6 or 8, capped at the lane depth
	always_comb begin
		stage_raw = 5'd2 + {2'b00, stage_select_q[7:6], 1'b0};
		if (stage_raw > 5'(MAX_STAGE_COUNT)) begin
			stages = CW'(MAX_STAGE_COUNT);
		end else begin
			stages = CW'(stage_raw);
		end
		// wet fraction above unity acts as unity
		wet_eff = (wet_mix_q > UNITY_Q16) ? UNITY_Q16 : wet_mix_q;
	end

	assign in_ch.ready = (state_q == T_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;

	// finished pair moves into the output register once it is free
	assign load_out = (state_q == T_OUT) && (!out_valid_q || out_ch.ready);

	always_comb begin
		coef_start      = accept && (in_ch.mode == MODE_PROCESS);
		lane_ctrl.clear = accept && (in_ch.mode == MODE_CLEAR);
		lane_ctrl.start = (state_q == T_COEF) && coef_done;
	end

	always_ff @(posedge clk) begin
		if (coef_start) begin
			smp_l_q <= signed'(in_ch.left_in);
			smp_r_q <= signed'(in_ch.right_in);
		end
	end

	// sequencer: coefficient, lanes, then hand off to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			lfo_phase_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.valid && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				T_IDLE: begin
					if (lane_ctrl.clear) begin
						lfo_phase_q <= '0;
					end else if (coef_start) begin
						state_q <= T_COEF;
					end
				end
				T_COEF: begin
					if (coef_done) begin
						state_q <= T_LANE;
					end
				end
				T_LANE: begin
					// both lanes run in lockstep
					if (done_l && done_r) begin
						state_q <= T_OUT;
					end
				end
				T_OUT: begin
					if (load_out) begin
						out_l_q     <= res_l;
						out_r_q     <= res_r;
						lfo_phase_q <= lfo_phase_q + lfo_step_q;
						state_q     <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.left_out  = out_l_q;
	assign out_ch.right_out = out_r_q;

	sap_coef #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) u_coef (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (coef_start),
		.phase      (lfo_phase_q),
		.depth      (sweep_depth_q),
		.sweep_low  (sweep_low_q),
		.sweep_high (sweep_high_q),
		.done       (coef_done),
		.coef       (coef)
	);

	sap_lane #(
		.MAX_STAGE_COUNT(MAX_STAGE_COUNT),
		.SAMPLE_BITS    (SAMPLE_BITS)
	) u_lane_l (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (lane_ctrl),
		.coef   (coef),
		.gain   (feedback_gain_q),
		.wet    (wet_eff),
		.stages (stages),
		.sample (smp_l_q),
		.done   (done_l),
		.result (res_l)
	);

	sap_lane #(
		.MAX_STAGE_COUNT(MAX_STAGE_COUNT),
		.SAMPLE_BITS    (SAMPLE_BITS)
	) u_lane_r (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (lane_ctrl),
		.coef   (coef),
		.gain   (feedback_gain_q),
		.wet    (wet_eff),
		.stages (stages),
		.sample (smp_r_q),
		.done   (done_r),
		.result (res_r)
	);

endmodule
